/* src/bds_pkg.sv */
// Shared constants, status codes and the item record for the baud divisor search.
package bds_pkg;

    localparam int DIVIDER_FIRST     = 4;
    localparam int DIVIDER_LAST      = 254;
    localparam int MAX_ERROR_PERCENT = 3;
    localparam int NUM_CELLS         = DIVIDER_LAST - DIVIDER_FIRST + 1;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 5;
    localparam int BD_W   = 8;
    localparam int DP1_W  = BD_W + 1;
    localparam int DEN_W  = WORD_W + DP1_W;
    localparam int REM_W  = DEN_W + 1;
    localparam int PCT_W  = WORD_W + 8;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_FAST  = 2'd1;
    localparam logic [1:0] ST_BAD_ERROR = 2'd2;
    localparam logic [1:0] ST_NO_RATE   = 2'd3;

    localparam logic CFG_CLOCK_HZ = 1'b0;
    localparam logic CFG_PRESCALE = 1'b1;

    localparam logic [WORD_W-1:0] CLOCK_HZ_RESET = 32'd100000000;

    typedef struct packed {
        logic [WORD_W-1:0] baud;
        logic [WORD_W-1:0] clk_eff;
        logic [1:0]        pre;
        logic              found;
        logic [WORD_W-1:0] best_err;
        logic [WORD_W-1:0] best_div;
        logic [BD_W-1:0]   best_bd;
    } item_t;

endpackage

/* src/bds_cell.sv */
// One search cell: tries a single baud divider with one serial divider shared by its two divisions.
module bds_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [bds_pkg::BD_W-1:0]       divider,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  bds_pkg::item_t                 up_item,
    output logic                           dn_valid,
    input  logic                           dn_ready,
    output bds_pkg::item_t                 dn_item
);
    import bds_pkg::*;

    localparam logic [2:0] S_EMPTY = 3'd0;
    localparam logic [2:0] S_MUL1  = 3'd1;
    localparam logic [2:0] S_DIV1  = 3'd2;
    localparam logic [2:0] S_MUL2  = 3'd3;
    localparam logic [2:0] S_DIV2  = 3'd4;
    localparam logic [2:0] S_CMP   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]        st_reg, st_next;
    item_t             item_reg, item_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [WORD_W-1:0] q_reg, q_next;
    logic [WORD_W-1:0] divq_reg, divq_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [DP1_W-1:0]  dp1;
    logic [REM_W-1:0]  rem_sh;
    logic              ge;
    logic [REM_W-1:0]  rem_step;
    logic [WORD_W-1:0] q_step;
    logic [WORD_W-1:0] err;

    assign dp1      = {1'b0, divider} + DP1_W'(1);
    assign rem_sh   = {rem_reg[REM_W-2:0], q_reg[WORD_W-1]};
    assign ge       = rem_sh >= REM_W'(den_reg);
    assign rem_step = ge ? rem_sh - REM_W'(den_reg) : rem_sh;
    assign q_step   = {q_reg[WORD_W-2:0], ge};
    assign err      = (q_reg > item_reg.baud) ? q_reg - item_reg.baud
                                              : item_reg.baud - q_reg;

    assign up_ready = (st_reg == S_EMPTY);
    assign dn_valid = (st_reg == S_DONE);
    assign dn_item  = item_reg;

    always_comb
    begin
        st_next   = st_reg;
        item_next = item_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        divq_next = divq_reg;
        cnt_next  = cnt_reg;
        unique case (st_reg)
            S_EMPTY:
            begin
                if (up_valid)
                begin
                    item_next = up_item;
                    st_next   = (up_item.pre == ST_OK) ? S_MUL1 : S_DONE;
                end
            end
            S_MUL1:
            begin
                den_next = DEN_W'(item_reg.baud) * DEN_W'(dp1);
                rem_next = '0;
                q_next   = item_reg.clk_eff;
                cnt_next = '0;
                st_next  = S_DIV1;
            end
            S_DIV1:
            begin
                rem_next = rem_step;
                q_next   = q_step;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    divq_next = q_step;
                    st_next   = S_MUL2;
                end
            end
            S_MUL2:
            begin
                // skip a divider whose divisor comes out zero
                if (divq_reg == '0)
                begin
                    st_next = S_DONE;
                end
                else
                begin
                    den_next = DEN_W'(divq_reg) * DEN_W'(dp1);
                    rem_next = '0;
                    q_next   = item_reg.clk_eff;
                    cnt_next = '0;
                    st_next  = S_DIV2;
                end
            end
            S_DIV2:
            begin
                rem_next = rem_step;
                q_next   = q_step;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    st_next = S_CMP;
                end
            end
            S_CMP:
            begin
                // strict compare keeps the earlier divider on a tie
                if (!item_reg.found || (err < item_reg.best_err))
                begin
                    item_next.found    = 1'b1;
                    item_next.best_err = err;
                    item_next.best_div = divq_reg;
                    item_next.best_bd  = divider;
                end
                st_next = S_DONE;
            end
            S_DONE:
            begin
                if (dn_ready)
                begin
                    st_next = S_EMPTY;
                end
            end
            default:
            begin
                st_next = S_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_EMPTY;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        divq_reg <= divq_next;
        cnt_reg  <= cnt_next;
    end

endmodule

/* src/bds_out.sv */
// Output stage: resolves the final status and holds the result transaction.
module bds_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  bds_pkg::item_t                up_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [bds_pkg::WORD_W-1:0]    clock_divisor,
    output logic [bds_pkg::BD_W-1:0]      baud_divider,
    output logic [bds_pkg::WORD_W-1:0]    rate_error
);
    import bds_pkg::*;

    logic              valid_reg, valid_next;
    logic [1:0]        status_reg, status_next;
    logic [WORD_W-1:0] div_reg, div_next;
    logic [BD_W-1:0]   bd_reg, bd_next;
    logic [WORD_W-1:0] err_reg, err_next;

    logic [PCT_W-1:0]  err_scaled;
    logic [PCT_W-1:0]  limit;
    logic              load;

    // floor(err * 100 / baud) > M  is  err * 100 >= (M + 1) * baud
    assign err_scaled = PCT_W'(up_item.best_err) * PCT_W'(100);
    assign limit      = PCT_W'(up_item.baud) * PCT_W'(MAX_ERROR_PERCENT + 1);

    assign up_ready = !valid_reg || !out_stall;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        valid_next  = valid_reg;
        status_next = status_reg;
        div_next    = div_reg;
        bd_next     = bd_reg;
        err_next    = err_reg;
        if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
            div_next   = '0;
            bd_next    = '0;
            err_next   = '0;
            if (up_item.pre == ST_TOO_FAST)
            begin
                status_next = ST_TOO_FAST;
            end
            else if ((up_item.pre == ST_NO_RATE) || !up_item.found)
            begin
                status_next = ST_NO_RATE;
            end
            else
            begin
                status_next = (err_scaled >= limit) ? ST_BAD_ERROR : ST_OK;
                div_next    = up_item.best_div;
                bd_next     = up_item.best_bd;
                err_next    = up_item.best_err;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        div_reg    <= div_next;
        bd_reg     <= bd_next;
        err_reg    <= err_next;
    end

    assign out_valid     = valid_reg;
    assign status        = status_reg;
    assign clock_divisor = div_reg;
    assign baud_divider  = bd_reg;
    assign rate_error    = err_reg;

endmodule

/* src/uart_baud_divisor_search.sv */
// Top level of the baud divisor search: config registers, entry check, cell chain, output.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------
//  in      | in_valid/in_stall  | requested_baud
//  out     | out_valid/out_stall| status, clock_divisor, baud_divider, rate_error
//  config  | wr_en              | wr_index, wr_data
//
// Each cell of the chain owns one baud divider. A transaction takes a multiply
// ahead of each of two 32-step serial divisions, then a compare and a handoff.
// A divider whose divisor is zero skips the second division and the compare.
// Rejected requests skip the multiplies, divisions and compare in each cell. A
// cell takes a new transaction only once it has handed on the last, with up to
// one transaction per cell in flight. Reset empties every cell and loads both
// config registers with their reset values. A stalled output holds its
// transaction; the chain backs up cell by cell behind it.
module uart_baud_divisor_search (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bds_pkg::WORD_W-1:0]    requested_baud,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [bds_pkg::WORD_W-1:0]    clock_divisor,
    output logic [bds_pkg::BD_W-1:0]      baud_divider,
    output logic [bds_pkg::WORD_W-1:0]    rate_error,
    input  logic                          wr_en,
    input  logic                          wr_index,
    input  logic [bds_pkg::WORD_W-1:0]    wr_data
);
    import bds_pkg::*;

    logic [WORD_W-1:0] clk_hz_reg, clk_hz_next;
    logic              prescale_reg, prescale_next;

    item_t entry_item;
    item_t chain_item  [0:NUM_CELLS];
    logic  chain_valid [0:NUM_CELLS];
    logic  chain_ready [0:NUM_CELLS];

    // Decode configuration writes; user writes only while the block is idle (unenforced).
    always_comb
    begin
        clk_hz_next   = clk_hz_reg;
        prescale_next = prescale_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_CLOCK_HZ: clk_hz_next   = wr_data;
                CFG_PRESCALE: prescale_next = wr_data[0];
                default:      clk_hz_next   = clk_hz_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg   <= CLOCK_HZ_RESET;
            prescale_reg <= 1'b0;
        end
        else
        begin
            clk_hz_reg   <= clk_hz_next;
            prescale_reg <= prescale_next;
        end
    end

    // Screen the request on entry: a zero rate first, then a rate above half
    // the undivided clock (also catches a zero clock). Both ride the chain
    // untouched and only pick up their status at the output.
    always_comb
    begin
        entry_item         = '0;
        entry_item.baud    = requested_baud;
        entry_item.clk_eff = prescale_reg ? (clk_hz_reg >> 3) : clk_hz_reg;
        if (requested_baud == '0)
        begin
            entry_item.pre = ST_NO_RATE;
        end
        else if ({requested_baud, 1'b0} > {1'b0, clk_hz_reg})
        begin
            entry_item.pre = ST_TOO_FAST;
        end
        else
        begin
            entry_item.pre = ST_OK;
        end
    end

    assign chain_valid[0] = in_valid;
    assign chain_item[0]  = entry_item;
    assign in_stall       = !chain_ready[0];

    // Dividers run in ascending order down the chain so a tie keeps the first.
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        localparam logic [BD_W-1:0] CellDivider = BD_W'(DIVIDER_FIRST + i);

        bds_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .divider  (CellDivider),
            .up_valid (chain_valid[i]),
            .up_ready (chain_ready[i]),
            .up_item  (chain_item[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_ready (chain_ready[i+1]),
            .dn_item  (chain_item[i+1])
        );
    end

    bds_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .up_valid      (chain_valid[NUM_CELLS]),
        .up_ready      (chain_ready[NUM_CELLS]),
        .up_item       (chain_item[NUM_CELLS]),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .clock_divisor (clock_divisor),
        .baud_divider  (baud_divider),
        .rate_error    (rate_error)
    );

endmodule

/* src/bds_checker.sv */
// Port-level checker for the baud divisor search, bound to the top level.
module bds_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [1:0]                    status,
    input logic [bds_pkg::WORD_W-1:0]    clock_divisor,
    input logic [bds_pkg::BD_W-1:0]      baud_divider,
    input logic [bds_pkg::WORD_W-1:0]    rate_error
);
    import bds_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_TOO_FAST || status == ST_NO_RATE)
        |-> clock_divisor == '0 && baud_divider == '0 && rate_error == '0)
        else $error("rejected request carries nonzero fields");

    a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK || status == ST_BAD_ERROR)
        |-> baud_divider >= BD_W'(DIVIDER_FIRST) && baud_divider <= BD_W'(DIVIDER_LAST)
            && clock_divisor != '0)
        else $error("reported divider or divisor out of range");

endmodule

bind uart_baud_divisor_search bds_checker u_bds_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .clock_divisor (clock_divisor),
    .baud_divider  (baud_divider),
    .rate_error    (rate_error)
);

/* bench/uart_baud_divisor_search_tb.sv */
// Self-checking bench for the baud divisor search: directed table, random rates, config phases.
module uart_baud_divisor_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bds_pkg::*;

    typedef struct {
        logic [1:0]  st;
        logic [31:0] div;
        logic [7:0]  bd;
        logic [31:0] err;
    } baud_fit_t;

    // One row of the directed table: a rate and, where it is obvious, the answer.
    typedef struct {
        logic [31:0] baud;
        bit          typed;
        baud_fit_t   fit;
    } rate_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] requested_baud = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [31:0] clock_divisor;
    logic [7:0]  baud_divider;
    logic [31:0] rate_error;
    logic        wr_en = 1'b0;
    logic        wr_index = CFG_CLOCK_HZ;
    logic [31:0] wr_data = '0;

    // Bench copy of the configuration registers.
    logic [31:0] clock_hz = CLOCK_HZ_RESET;
    logic        prescale = 1'b0;

    baud_fit_t pending_fits[$];
    int        fail_count = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    int        hold_left = 0;

    uart_baud_divisor_search dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .requested_baud(requested_baud),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .clock_divisor(clock_divisor), .baud_divider(baud_divider),
        .rate_error(rate_error),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    always #5 clk = ~clk;

    // Search every divider for the closest achievable rate, all math at 64 bits.
    function automatic baud_fit_t fit_baud(logic [31:0] rate);
        baud_fit_t   r;
        logic [63:0] b, f, dv, ach, e, best_e;
        bit          found;
        r = '{ST_OK, 32'd0, 8'd0, 32'd0};
        b = 64'(rate);
        f = 64'(clock_hz);
        found = 0;
        best_e = '0;
        if (b == 0) begin
            r.st = ST_NO_RATE;
            return r;
        end
        if (b * 2 > f) begin
            r.st = ST_TOO_FAST;
            return r;
        end
        if (prescale)
            f = f / 8;
        for (int d = DIVIDER_FIRST; d <= DIVIDER_LAST; d++) begin
            dv = f / (b * 64'(d + 1));
            if (dv == 0)
                continue;
            ach = f / (dv * 64'(d + 1));
            e = (ach > b) ? ach - b : b - ach;
            // strict compare keeps the first divider on a tie
            if (!found || e < best_e) begin
                found = 1;
                best_e = e;
                r.div = dv[31:0];
                r.bd = 8'(d);
                r.err = e[31:0];
            end
        end
        if (!found) begin
            r = '{ST_NO_RATE, 32'd0, 8'd0, 32'd0};
            return r;
        end
        if ((best_e * 100) / b > 64'(MAX_ERROR_PERCENT))
            r.st = ST_BAD_ERROR;
        return r;
    endfunction

    // Receiver: random stall, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Check every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        baud_fit_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_fits.size() == 0)
            begin
                $error("result with nothing expected: status %0d", status);
                fail_count++;
            end
            else
            begin
                want = pending_fits.pop_front();
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    fail_count++;
                end
                if (clock_divisor !== want.div)
                begin
                    $error("clock_divisor: expected %0d, got %0d", want.div, clock_divisor);
                    fail_count++;
                end
                if (baud_divider !== want.bd)
                begin
                    $error("baud_divider: expected %0d, got %0d", want.bd, baud_divider);
                    fail_count++;
                end
                if (rate_error !== want.err)
                begin
                    $error("rate_error: expected %0d, got %0d", want.err, rate_error);
                    fail_count++;
                end
            end
        end
    end

    // Offer one transaction, with random idle cycles first; hold it until accepted.
    task automatic send_rate(logic [31:0] rate, baud_fit_t fit);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        requested_baud <= rate;
        do
            @(posedge clk);
        while (in_stall);
        pending_fits.push_back(fit);
        @(negedge clk);
    endtask

    // Drop valid, drain the chain, then write both registers.
    task automatic set_config(logic [31:0] hz, logic pre);
        in_valid <= 1'b0;
        while (pending_fits.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= CFG_CLOCK_HZ;
        wr_data <= hz;
        @(negedge clk);
        wr_index <= CFG_PRESCALE;
        // upper bits are don't-care for the prescale register
        wr_data <= {31'($urandom), pre};
        @(negedge clk);
        wr_en <= 1'b0;
        clock_hz = hz;
        prescale = pre;
    endtask

    // Mostly legal rates, with zero, full-range and near-limit rates mixed in.
    function automatic logic [31:0] pick_rate();
        int unsigned sel;
        logic [31:0] half;
        sel = $urandom_range(99);
        half = clock_hz >> 1;
        if (sel < 4)
            return 32'd0;
        else if (sel < 12)
            return $urandom;
        else if (sel < 22)
            return half + 32'($urandom_range(4)) - 32'd2;
        else if (sel < 60)
            return $urandom_range(1, 2000000);
        else
            return $urandom_range(1, (half == 0) ? 1 : half);
    endfunction

    initial
    begin
        rate_row_t   rows[$];
        logic [31:0] cfg_hz[8];
        logic        cfg_pre[8];
        logic [31:0] rate;

        rows = '{
            '{32'd0,          1, '{ST_NO_RATE,  32'd0, 8'd0, 32'd0}},
            '{32'hFFFF_FFFF,  1, '{ST_TOO_FAST, 32'd0, 8'd0, 32'd0}},
            '{32'h8000_0000,  1, '{ST_TOO_FAST, 32'd0, 8'd0, 32'd0}},
            '{32'h5555_5555,  1, '{ST_TOO_FAST, 32'd0, 8'd0, 32'd0}},
            '{32'hAAAA_AAAA,  1, '{ST_TOO_FAST, 32'd0, 8'd0, 32'd0}},
            '{32'd50000001,   1, '{ST_TOO_FAST, 32'd0, 8'd0, 32'd0}},
            // exactly half the clock passes the entry check but no divider fits
            '{32'd50000000,   1, '{ST_NO_RATE,  32'd0, 8'd0, 32'd0}},
            '{32'd1,          0, '{ST_OK, 32'd0, 8'd0, 32'd0}},
            '{32'd2,          0, '{ST_OK, 32'd0, 8'd0, 32'd0}},
            '{32'd9600,       0, '{ST_OK, 32'd0, 8'd0, 32'd0}},
            '{32'd115200,     0, '{ST_OK, 32'd0, 8'd0, 32'd0}},
            '{32'd921600,     0, '{ST_OK, 32'd0, 8'd0, 32'd0}},
            // coarse divisors: 15000000 and 12000000 leave a large error, 20000000 fits exactly
            '{32'd15000000,   0, '{ST_OK, 32'd0, 8'd0, 32'd0}},
            '{32'd12000000,   0, '{ST_OK, 32'd0, 8'd0, 32'd0}},
            '{32'd20000000,   0, '{ST_OK, 32'd0, 8'd0, 32'd0}}
        };
        cfg_hz  = '{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1843200,
                    32'd7, $urandom, $urandom_range(1000, 50000000), CLOCK_HZ_RESET};
        cfg_pre = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

        // hold reset, then release it on a falling edge
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_rate(rows[i].baud, rows[i].typed ? rows[i].fit : fit_baud(rows[i].baud));

        // random part: one config setting per phase, idle mode rotating
        for (int ph = 0; ph < 8; ph++)
        begin
            set_config(cfg_hz[ph], cfg_pre[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 58; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 58; end
                default: begin send_idle_pct = 8; stall_pct = 8; end
            endcase
            for (int n = 0; n < ((ph == 2) ? 400 : 230); n++)
            begin
                // long receiver hold-off while more transactions are offered
                // than the chain holds: it fills and stalls the input
                if (ph == 2 && n == 0)
                    hold_left = 30000;
                rate = pick_rate();
                send_rate(rate, fit_baud(rate));
            end
        end
        in_valid <= 1'b0;

        while (pending_fits.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #40ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

/* uart_baud_divisor_search.f */
src/bds_pkg.sv
src/bds_cell.sv
src/bds_out.sv
src/uart_baud_divisor_search.sv
src/bds_checker.sv
bench/uart_baud_divisor_search_tb.sv
